/* hw/rtl/gnmg_pkg.sv */
// ----------------------------------------------------------------------------
// gnmg_pkg
// shared constants and controller/datapath interface types for the grid
// neighbour move generator
// ----------------------------------------------------------------------------
package gnmg_pkg;

   // fixed field widths
   localparam int CELL_W = 12;
   localparam int CFG_W  = 7;
   localparam int NB_N   = 8;

   // built grid size defaults
   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;

   // register reset values
   localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = 7'd64;
   localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = 7'd64;

   // register indexes
   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   // item function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic size_en;
      logic wr_en;
      logic div_start;
      logic rd_en;
      logic mask_en;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic func;
      logic in_range;
      logic div_done;
      logic rd_done;
      logic last;
   } sts_type;

endpackage

/* hw/rtl/gnmg_div.sv */
// ----------------------------------------------------------------------------
// gnmg_div
// restoring bit-serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gnmg_div #(
   parameter int DVS_W = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gnmg_pkg::CELL_W-1:0] dividend,
   input  logic [DVS_W-1:0]            divisor,
   output logic [gnmg_pkg::CELL_W-1:0] quotient,
   output logic [DVS_W-1:0]            remainder,
   output logic                        done
);

   localparam int CNT_W = $clog2(gnmg_pkg::CELL_W);

   logic                        busy_ff, busy_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [gnmg_pkg::CELL_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0]            rem_ff, rem_in;
   logic [DVS_W:0]              trial;
   logic [DVS_W:0]              diff;
   logic                        fits;

   assign trial = {rem_ff, quo_ff[gnmg_pkg::CELL_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(gnmg_pkg::CELL_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[gnmg_pkg::CELL_W-2:0], fits};
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   // last step completes at the edge where done is seen
   assign done      = busy_ff && (cnt_ff == '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* hw/rtl/gnmg_dpath.sv */
// ----------------------------------------------------------------------------
// gnmg_dpath
// passability store, range check, coordinate split, neighbour scan and
// result register
// ----------------------------------------------------------------------------
module gnmg_dpath #(
   parameter int MAX_WIDTH  = gnmg_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gnmg_pkg::MAX_HEIGHT_DEF,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gnmg_pkg::cmd_type           cmd,
   output gnmg_pkg::sts_type           sts,
   input  logic [WW-1:0]               map_w,
   input  logic [HW-1:0]               map_h,
   input  logic                        req_func,
   input  logic [gnmg_pkg::CELL_W-1:0] req_cell_index,
   input  logic                        req_cell_passable,
   output logic [gnmg_pkg::CELL_W-1:0] rsp_neighbour_index,
   output logic                        rsp_is_diagonal,
   output logic                        rsp_no_moves,
   output logic                        rsp_last
);

   localparam int CELL_W = gnmg_pkg::CELL_W;
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = $clog2(DEPTH);
   localparam int SW     = WW + HW;
   localparam int CMPW   = (SW > CELL_W) ? SW : CELL_W;
   localparam int NW     = ((AW > CELL_W) ? AW : CELL_W) + 1;
   localparam int CW     = ((CELL_W > HW) ? CELL_W : HW) + 1;
   localparam int NB_N   = gnmg_pkg::NB_N;

   // passability store
   logic passable_mem [DEPTH];

   logic              func_ff, func_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              pass_ff, pass_in;
   logic [SW-1:0]     size_ff, size_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [3:0]        scan_ff, scan_in;
   logic              cap_ff, cap_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [2:0]        rd_pos_ff, rd_pos_in;
   logic              mem_q_ff;
   logic [NB_N-1:0]   nb_ff, nb_in;
   logic [NB_N-1:0]   mask_ff, mask_in;
   logic [CELL_W-1:0] out_idx_ff, out_idx_in;
   logic              out_diag_ff, out_diag_in;
   logic              out_none_ff, out_none_in;
   logic              out_last_ff, out_last_in;

   logic              in_range;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic              mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic              issue;

   logic [CELL_W-1:0] cy;
   logic [WW-1:0]     cx;
   logic              div_done;
   logic              at_left, at_right, at_up, at_down;
   logic [NB_N-1:0]   grid_ok;
   logic [NW-1:0]     row_up, row_mid, row_dn;
   logic [NW-1:0]     nb_addr [NB_N];
   logic [NB_N-1:0]   perm;
   logic [NB_N-1:0]   diag_pos;
   logic [2:0]        sel;
   logic [NB_N-1:0]   mask_rest;

   gnmg_div #(
      .DVS_W (WW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (cell_ff),
      .divisor   (map_w),
      .quotient  (cy),
      .remainder (cx),
      .done      (div_done)
   );

   assign in_range = CMPW'(cell_ff) < CMPW'(size_ff);

   // neighbour position order: up-left, up, up-right, left, right,
   // down-left, down, down-right
   assign at_left  = cx != '0;
   assign at_right = ({1'b0, cx} + (WW + 1)'(1)) < {1'b0, map_w};
   assign at_up    = cy != '0;
   assign at_down  = (CW'(cy) + CW'(1)) < CW'(map_h);

   assign grid_ok = {at_down & at_right, at_down, at_down & at_left,
                     at_right, at_left,
                     at_up & at_right, at_up, at_up & at_left};

   assign diag_pos = 8'b1010_0101;

   assign row_mid = NW'(cell_ff);
   assign row_up  = row_mid - NW'(map_w);
   assign row_dn  = row_mid + NW'(map_w);

   assign nb_addr[0] = row_up - NW'(1);
   assign nb_addr[1] = row_up;
   assign nb_addr[2] = row_up + NW'(1);
   assign nb_addr[3] = row_mid - NW'(1);
   assign nb_addr[4] = row_mid + NW'(1);
   assign nb_addr[5] = row_dn - NW'(1);
   assign nb_addr[6] = row_dn;
   assign nb_addr[7] = row_dn + NW'(1);

   // diagonals need both orthogonal cells beside them
   assign perm[0] = nb_ff[0] & nb_ff[1] & nb_ff[3];
   assign perm[1] = nb_ff[1];
   assign perm[2] = nb_ff[2] & nb_ff[1] & nb_ff[4];
   assign perm[3] = nb_ff[3];
   assign perm[4] = nb_ff[4];
   assign perm[5] = nb_ff[5] & nb_ff[6] & nb_ff[3];
   assign perm[6] = nb_ff[6];
   assign perm[7] = nb_ff[7] & nb_ff[6] & nb_ff[4];

   // lowest pending move
   always_comb begin
      sel = '0;
      for (int i = NB_N - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = 3'(i);
         end
      end
   end

   assign mask_rest = mask_ff & ~(NB_N'(1) << sel);

   assign issue     = cmd.rd_en && (scan_ff != 4'(NB_N));
   assign mem_raddr = AW'(nb_addr[scan_ff[2:0]]);
   assign mem_we    = cmd.clear_en | cmd.wr_en;
   assign mem_waddr = cmd.clear_en ? clr_addr_ff : AW'(cell_ff);
   assign mem_wdata = cmd.clear_en ? 1'b0 : pass_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         passable_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= passable_mem[mem_raddr];
   end

   always_comb begin
      func_in     = func_ff;
      cell_in     = cell_ff;
      pass_in     = pass_ff;
      size_in     = size_ff;
      clr_addr_in = clr_addr_ff;
      scan_in     = scan_ff;
      cap_in      = issue;
      rd_vld_in   = grid_ok[scan_ff[2:0]];
      rd_pos_in   = scan_ff[2:0];
      nb_in       = nb_ff;
      mask_in     = mask_ff;
      out_idx_in  = out_idx_ff;
      out_diag_in = out_diag_ff;
      out_none_in = out_none_ff;
      out_last_in = out_last_ff;

      if (cmd.clear_en) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end

      if (cmd.accept) begin
         func_in = req_func;
         cell_in = req_cell_index;
         pass_in = req_cell_passable;
         mask_in = '0;
      end

      if (cmd.size_en) begin
         size_in = SW'(map_w) * SW'(map_h);
      end

      if (cmd.div_start) begin
         scan_in = '0;
      end else if (issue) begin
         scan_in = scan_ff + 4'd1;
      end

      if (cap_ff) begin
         nb_in[rd_pos_ff] = rd_vld_ff & mem_q_ff;
      end

      if (cmd.mask_en) begin
         mask_in = perm;
      end

      if (cmd.out_load) begin
         if (mask_ff == '0) begin
            out_idx_in  = '0;
            out_diag_in = 1'b0;
            out_none_in = 1'b1;
            out_last_in = 1'b1;
         end else begin
            out_idx_in  = CELL_W'(nb_addr[sel]);
            out_diag_in = diag_pos[sel];
            out_none_in = 1'b0;
            out_last_in = (mask_rest == '0);
            mask_in     = mask_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         scan_ff     <= '0;
         cap_ff      <= 1'b0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         scan_ff     <= scan_in;
         cap_ff      <= cap_in;
      end
      func_ff     <= func_in;
      cell_ff     <= cell_in;
      pass_ff     <= pass_in;
      size_ff     <= size_in;
      rd_vld_ff   <= rd_vld_in;
      rd_pos_ff   <= rd_pos_in;
      nb_ff       <= nb_in;
      mask_ff     <= mask_in;
      out_idx_ff  <= out_idx_in;
      out_diag_ff <= out_diag_in;
      out_none_ff <= out_none_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      sts.clear_done = clr_addr_ff == AW'(DEPTH - 1);
      sts.func       = func_ff;
      sts.in_range   = in_range;
      sts.div_done   = div_done;
      sts.rd_done    = scan_ff == 4'(NB_N);
      sts.last       = out_last_ff;
   end

   assign rsp_neighbour_index = out_idx_ff;
   assign rsp_is_diagonal     = out_diag_ff;
   assign rsp_no_moves        = out_none_ff;
   assign rsp_last            = out_last_ff;

endmodule

/* hw/rtl/gnmg_ctrl.sv */
// ----------------------------------------------------------------------------
// gnmg_ctrl
// sequencing state machine: store clear, item intake, divide, neighbour
// scan and result transfers
// ----------------------------------------------------------------------------
module gnmg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gnmg_pkg::cmd_type cmd,
   input  gnmg_pkg::sts_type sts
);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_SIZE  = 4'd2;
   localparam logic [3:0] ST_TEST  = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_READ  = 4'd5;
   localparam logic [3:0] ST_MASK  = 4'd6;
   localparam logic [3:0] ST_LOAD  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.size_en = 1'b1;
            state_in    = ST_TEST;
         end
         ST_TEST: begin
            if (sts.func == gnmg_pkg::FUNC_WRITE) begin
               cmd.wr_en = sts.in_range;
               state_in  = ST_IDLE;
            end else if (sts.in_range) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            if (sts.rd_done) begin
               state_in = ST_MASK;
            end
         end
         ST_MASK: begin
            cmd.mask_en = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.out_load = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (sts.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.out_load = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/grid_neighbour_move_generator.sv */
// ----------------------------------------------------------------------------
// grid_neighbour_move_generator
// one passability bit per grid cell; write items set a bit, query items
// list the permitted 8-connected moves from a cell without corner cutting
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------------
//  req     | in  | req_valid/req_stall | func, cell_index, cell_passable
//  rsp     | out | rsp_valid/rsp_stall | neighbour_index, is_diagonal, no_moves, last
//  csr     | in  | csr_wr_en           | csr_index, csr_wr_data
//
//  reset clears all MAX_WIDTH * MAX_HEIGHT store cells, one cell a cycle, 4096 cells by default
//  write item: after the transfer it passes the size and test states before req is ready again
//  query in the grid: size and range check, bit-serial divide, neighbour store reads, mask and
//  load steps to build the list, then one result a cycle while rsp does not stall
//  query outside the grid: single no-moves result after the size, test and load states
//  one item at a time; req stalls until the last rsp transfer, rsp stalls hold the result
//
module grid_neighbour_move_generator #(
   parameter int MAX_WIDTH  = gnmg_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gnmg_pkg::MAX_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // item channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [gnmg_pkg::CELL_W-1:0] req_cell_index,
   input  logic                        req_cell_passable,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [gnmg_pkg::CELL_W-1:0] rsp_neighbour_index,
   output logic                        rsp_is_diagonal,
   output logic                        rsp_no_moves,
   output logic                        rsp_last,
   // register write port
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [gnmg_pkg::CFG_W-1:0]  csr_wr_data
);

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int CFG_W = gnmg_pkg::CFG_W;

   logic [CFG_W-1:0] map_width_ff, map_width_in;
   logic [CFG_W-1:0] map_height_ff, map_height_in;
   logic [WW-1:0]    map_w;
   logic [HW-1:0]    map_h;

   gnmg_pkg::cmd_type cmd;
   gnmg_pkg::sts_type sts;

   // register writes, any other index is dropped
   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            gnmg_pkg::CSR_MAP_WIDTH:  map_width_in  = csr_wr_data;
            gnmg_pkg::CSR_MAP_HEIGHT: map_height_in = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= gnmg_pkg::MAP_WIDTH_RST;
         map_height_ff <= gnmg_pkg::MAP_HEIGHT_RST;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   // zero reads as one, anything past the built size reads as the maximum
   always_comb begin
      if (map_width_ff == '0) begin
         map_w = WW'(1);
      end else if (32'(map_width_ff) > 32'(MAX_WIDTH)) begin
         map_w = WW'(MAX_WIDTH);
      end else begin
         map_w = WW'(map_width_ff);
      end
      if (map_height_ff == '0) begin
         map_h = HW'(1);
      end else if (32'(map_height_ff) > 32'(MAX_HEIGHT)) begin
         map_h = HW'(MAX_HEIGHT);
      end else begin
         map_h = HW'(map_height_ff);
      end
   end

   // sequencing
   gnmg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // store, divider, neighbour scan and result register
   gnmg_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .map_w               (map_w),
      .map_h               (map_h),
      .req_func            (req_func),
      .req_cell_index      (req_cell_index),
      .req_cell_passable   (req_cell_passable),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_is_diagonal     (rsp_is_diagonal),
      .rsp_no_moves        (rsp_no_moves),
      .rsp_last            (rsp_last)
   );

endmodule

/* tb/grid_neighbour_move_generator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_neighbour_move_generator_tb
// self-checking bench: a queue-fed driver sends write and query items, a
// clocked monitor compares every result transfer against moves predicted
// from a private copy of the passability grid and the grid size registers
// ----------------------------------------------------------------------------
module grid_neighbour_move_generator_tb;

   localparam int CELL_W      = gnmg_pkg::CELL_W;
   localparam int CFG_W       = gnmg_pkg::CFG_W;
   localparam int GRID_MAX_W  = gnmg_pkg::MAX_WIDTH_DEF;
   localparam int GRID_MAX_H  = gnmg_pkg::MAX_HEIGHT_DEF;
   localparam int STORE_CELLS = GRID_MAX_W * GRID_MAX_H;

   localparam logic             FUNC_WRITE     = gnmg_pkg::FUNC_WRITE;
   localparam logic             FUNC_QUERY     = gnmg_pkg::FUNC_QUERY;
   localparam logic             CSR_MAP_WIDTH  = gnmg_pkg::CSR_MAP_WIDTH;
   localparam logic             CSR_MAP_HEIGHT = gnmg_pkg::CSR_MAP_HEIGHT;
   localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = gnmg_pkg::MAP_WIDTH_RST;
   localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = gnmg_pkg::MAP_HEIGHT_RST;

   // one item on the request channel
   typedef struct packed {
      logic              func;
      logic [CELL_W-1:0] pos;
      logic              pass;
   } grid_item_type;

   // one permitted move on the result channel
   typedef struct packed {
      logic [CELL_W-1:0] nb;
      logic              diag;
      logic              none;
      logic              last;
   } move_type;

   logic              clock;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_stall;
   logic              req_func          = FUNC_WRITE;
   logic [CELL_W-1:0] req_cell_index    = '0;
   logic              req_cell_passable = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall         = 1'b0;
   logic [CELL_W-1:0] rsp_neighbour_index;
   logic              rsp_is_diagonal;
   logic              rsp_no_moves;
   logic              rsp_last;
   logic              csr_wr_en         = 1'b0;
   logic              csr_index         = CSR_MAP_WIDTH;
   logic [CFG_W-1:0]  csr_wr_data       = '0;

   // predictor state: mirror of the grid store and the size registers
   bit                ground_bits [STORE_CELLS];
   logic [CFG_W-1:0]  grid_cols = MAP_WIDTH_RST;
   logic [CFG_W-1:0]  grid_rows = MAP_HEIGHT_RST;

   grid_item_type     grid_items [$];      // items waiting to be offered
   move_type          expected_moves [$];  // moves still owed by the block
   int                mismatches   = 0;
   int                items_taken  = 0;
   int                items_queued = 0;
   bit                calm_run     = 1'b0;  // no idling on either side
   logic              hold_rsp     = 1'b0;  // long receiver hold-off

   // driver and monitor working variables
   bit                req_fire;
   int                send_wait = 0;
   int                recv_wait = 0;
   grid_item_type     next_item;
   move_type          want_move;

   grid_neighbour_move_generator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_cell_index      (req_cell_index),
      .req_cell_passable   (req_cell_passable),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_is_diagonal     (rsp_is_diagonal),
      .rsp_no_moves        (rsp_no_moves),
      .rsp_last            (rsp_last),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // zero acts as one, anything past the built size acts as the maximum
   function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic bit open_at(input int x, input int y, input int w);
      int idx;
      idx = x + y * w;
      if (idx >= STORE_CELLS) return 1'b0;
      return ground_bits[idx];
   endfunction

   // apply one accepted item and queue the moves it must produce
   function automatic void predict_moves(input logic func, input logic [CELL_W-1:0] pos,
                                         input logic pass);
      int       w;
      int       h;
      int       cx;
      int       cy;
      int       nx;
      int       ny;
      bit       diag;
      move_type mv;
      move_type found [$];
      w = clamp_dim(grid_cols, GRID_MAX_W);
      h = clamp_dim(grid_rows, GRID_MAX_H);
      if (func == FUNC_WRITE) begin
         // writes outside the grid are dropped
         if (pos < w * h) ground_bits[pos] = pass;
         return;
      end
      if (pos < w * h) begin
         cx = pos % w;
         cy = pos / w;
         // row above, same row, row below; left to right within each
         for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
               nx = cx + dx;
               ny = cy + dy;
               if (dx == 0 && dy == 0) continue;
               if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
               if (!open_at(nx, ny, w)) continue;
               diag = (dx != 0) && (dy != 0);
               // no corner cutting: both side cells must be open too
               if (diag && !(open_at(cx, ny, w) && open_at(nx, cy, w))) continue;
               mv.nb   = CELL_W'(nx + ny * w);
               mv.diag = diag;
               mv.none = 1'b0;
               mv.last = 1'b0;
               found.push_back(mv);
            end
         end
      end
      if (found.size() == 0) begin
         // empty list, including cells outside the grid
         mv.nb   = '0;
         mv.diag = 1'b0;
         mv.none = 1'b1;
         mv.last = 1'b1;
         found.push_back(mv);
      end else begin
         found[found.size()-1].last = 1'b1;
      end
      foreach (found[i]) expected_moves.push_back(found[i]);
   endfunction

   // per-transfer random wait, none during calm stretches
   function automatic int draw_wait();
      if (calm_run) return 0;
      return $urandom_range(0, 9);
   endfunction

   function automatic void compare_field(input string what, input logic [CELL_W-1:0] want,
                                         input logic [CELL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // ------------------------------------------------------------------
   // request driver: offers queued items, predicts on each transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            predict_moves(req_func, req_cell_index, req_cell_passable);
            items_taken++;
            send_wait = draw_wait();
         end
         // payload only moves once the current item has transferred
         if (!req_valid || req_fire) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (grid_items.size() != 0) begin
               next_item = grid_items.pop_front();
               req_valid         <= 1'b1;
               req_func          <= next_item.func;
               req_cell_index    <= next_item.pos;
               req_cell_passable <= next_item.pass;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result monitor: checks each transfer against the oldest move owed
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_moves.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                        $time, rsp_neighbour_index, rsp_is_diagonal, rsp_no_moves,
                        rsp_last);
               mismatches++;
            end else begin
               want_move = expected_moves.pop_front();
               compare_field("neighbour_index", want_move.nb, rsp_neighbour_index);
               compare_field("is_diagonal", CELL_W'(want_move.diag), CELL_W'(rsp_is_diagonal));
               compare_field("no_moves", CELL_W'(want_move.none), CELL_W'(rsp_no_moves));
               compare_field("last", CELL_W'(want_move.last), CELL_W'(rsp_last));
            end
            recv_wait = draw_wait();
         end
         // while idle, sometimes stall ahead so the first result of a query waits too
         if (recv_wait == 0 && !rsp_valid && $urandom_range(0, 3) == 0) recv_wait = draw_wait();
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // long receiver hold-off in the random part: the block backs up and stalls req
   initial begin
      wait (items_taken >= 150);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic queue_item(input logic func, input int pos, input logic pass);
      grid_item_type it;
      it.func = func;
      it.pos  = CELL_W'(pos);
      it.pass = pass;
      grid_items.push_back(it);
      items_queued++;
   endtask

   // wait until every queued item has transferred and every move has come
   // back, then give a trailing write item time to finish inside the block
   task automatic drain();
      while (items_taken != items_queued || expected_moves.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // size registers are only written with the block idle
   task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_MAP_WIDTH;
      csr_wr_data <= w;
      @(posedge clock);
      csr_index   <= CSR_MAP_HEIGHT;
      csr_wr_data <= h;
      grid_cols = w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      grid_rows = h;
   endtask

   // random items clustered in a small window so neighbourhoods fill up,
   // with edge cells and fully random indexes mixed in
   task automatic random_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                               input int count, input bit quiet);
      int w_eff;
      int h_eff;
      int bx;
      int by;
      int x;
      int y;
      int r;
      int density;
      w_eff = clamp_dim(w, GRID_MAX_W);
      h_eff = clamp_dim(h, GRID_MAX_H);
      drain();
      set_grid(w, h);
      calm_run = quiet;
      density = $urandom_range(45, 95);
      bx = 0;
      by = 0;
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 0) begin
            bx = $urandom_range(0, w_eff - 1);
            by = $urandom_range(0, h_eff - 1);
         end
         r = $urandom_range(0, 99);
         if (r < 8) begin
            queue_item(1'($urandom_range(0, 1)), $urandom_range(0, STORE_CELLS - 1),
                       1'($urandom_range(0, 1)));
         end else begin
            x = (bx + $urandom_range(0, 3)) % w_eff;
            y = (by + $urandom_range(0, 3)) % h_eff;
            if (r < 16) x = ($urandom_range(0, 1) != 0) ? w_eff - 1 : 0;
            if (r >= 16 && r < 24) y = ($urandom_range(0, 1) != 0) ? h_eff - 1 : 0;
            queue_item(($urandom_range(0, 99) < 55) ? FUNC_WRITE : FUNC_QUERY,
                       x + y * w_eff, $urandom_range(0, 99) < density);
         end
      end
   endtask

   initial begin
      logic [CFG_W-1:0] widths  [10];
      logic [CFG_W-1:0] heights [10];
      widths  = '{7'd64, 7'd5, 7'd1, 7'd64, 7'd2, 7'd3, 7'd64, 7'd9, 7'd127, 7'd0};
      heights = '{7'd64, 7'd4, 7'd1, 7'd1, 7'd2, 7'd64, 7'd64, 7'd7, 7'd127, 7'd0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, default 64 x 64 grid; the store clear after reset shows up
      // as a long req stall before the first transfer
      calm_run = 1'b1;
      queue_item(FUNC_WRITE, 0, 1'b1);
      queue_item(FUNC_WRITE, 1, 1'b1);
      queue_item(FUNC_WRITE, 64, 1'b1);
      queue_item(FUNC_QUERY, 65, 1'b0);    // blocked cell still lists its moves
      queue_item(FUNC_QUERY, 0, 1'b0);     // top-left corner, diagonal blocked
      queue_item(FUNC_WRITE, 65, 1'b1);
      queue_item(FUNC_QUERY, 0, 1'b1);     // corner with the diagonal open
      queue_item(FUNC_WRITE, 4095, 1'b1);
      queue_item(FUNC_QUERY, 4095, 1'b1);  // bottom-right corner, no moves
      queue_item(FUNC_QUERY, 4094, 1'b0);
      queue_item(FUNC_WRITE, 1, 1'b0);
      queue_item(FUNC_QUERY, 65, 1'b1);    // side cell closed, no corner cutting
      queue_item(FUNC_QUERY, 64, 1'b0);
      drain();

      // width zero acts as one column, height past the maximum as 64 rows;
      // old bits are read under the new layout
      set_grid(7'd0, 7'd127);
      queue_item(FUNC_QUERY, 0, 1'b0);
      queue_item(FUNC_WRITE, 2, 1'b1);
      queue_item(FUNC_WRITE, 3, 1'b1);
      queue_item(FUNC_QUERY, 2, 1'b0);
      queue_item(FUNC_WRITE, 64, 1'b0);    // outside the grid, dropped
      queue_item(FUNC_QUERY, 64, 1'b1);    // outside the grid, no moves
      queue_item(FUNC_QUERY, 4095, 1'b0);
      drain();

      // one row, every column
      set_grid(7'd127, 7'd0);
      queue_item(FUNC_QUERY, 0, 1'b1);
      queue_item(FUNC_WRITE, 62, 1'b1);
      queue_item(FUNC_QUERY, 63, 1'b0);
      queue_item(FUNC_QUERY, 64, 1'b1);

      // random part, about 480 items over ten grid size settings; two run without idling
      foreach (widths[p])
         random_phase(widths[p], heights[p], 48, (p == 3) || (p == 6));

      drain();
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/gnmg_pkg.sv
hw/rtl/gnmg_div.sv
hw/rtl/gnmg_dpath.sv
hw/rtl/gnmg_ctrl.sv
hw/rtl/grid_neighbour_move_generator.sv
tb/grid_neighbour_move_generator_tb.sv
